### rtl/core/trm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_pkg
// Shared types and constants of the throughput rate meter.
// ----------------------------------------------------------------------------
package trm_pkg;

    localparam int DATA_W = 64;
    localparam int CNT_W  = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        word_t quotient;
    } div_rsp_t;

endpackage

### rtl/core/trm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_if
// Sample and result channels of the throughput rate meter.
// ----------------------------------------------------------------------------
interface trm_sample_if;
    import trm_pkg::*;

    logic  valid;
    logic  ready;
    word_t message_total;
    word_t byte_total;
    word_t sample_time;

    modport source (
        output valid,
        output message_total,
        output byte_total,
        output sample_time,
        input  ready
    );

    modport sink (
        input  valid,
        input  message_total,
        input  byte_total,
        input  sample_time,
        output ready
    );
endinterface

interface trm_result_if;
    import trm_pkg::*;

    logic  valid;
    logic  ready;
    word_t message_rate;
    word_t byte_rate;
    logic  updated;

    modport source (
        output valid,
        output message_rate,
        output byte_rate,
        output updated,
        input  ready
    );

    modport sink (
        input  valid,
        input  message_rate,
        input  byte_rate,
        input  updated,
        output ready
    );
endinterface

### rtl/core/trm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trm_div
    import trm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            rem_reg, rem_next;
    word_t            quo_reg, quo_next;
    word_t            dvs_reg, dvs_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W+1])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("done without a finished run");

    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("run ended without done");
`endif

endmodule

### rtl/core/throughput_rate_meter.sv
`timescale 1ns / 1ps
// Flow: a sample beat is registered in S_IDLE and checked in S_CHECK; when the
//   time advances, the message and byte rates come from two 64-step runs of
//   the shared restoring divider before S_OUT, else S_OUT follows S_CHECK.
// A new sample is taken only in S_IDLE, after the result beat is accepted.
// Reset: asynchronous, clears stored time, totals and held rates to zero.
// ----------------------------------------------------------------------------
// throughput_rate_meter
// Message and byte rates from running totals and timestamps.
// ----------------------------------------------------------------------------
module throughput_rate_meter
    import trm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    trm_sample_if.sink          samples,
    trm_result_if.source        rates
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MSG_GO,
        S_MSG_WAIT,
        S_BYTE_GO,
        S_BYTE_WAIT,
        S_OUT
    } state_t;

    state_t   state_reg, state_next;
    word_t    smp_msg_reg, smp_msg_next;
    word_t    smp_byte_reg, smp_byte_next;
    word_t    smp_time_reg, smp_time_next;
    word_t    last_time_reg, last_time_next;
    word_t    last_msg_reg, last_msg_next;
    word_t    last_byte_reg, last_byte_next;
    word_t    elapsed_reg, elapsed_next;
    word_t    rise_msg_reg, rise_msg_next;
    word_t    rise_byte_reg, rise_byte_next;
    word_t    msg_rate_reg, msg_rate_next;
    word_t    byte_rate_reg, byte_rate_next;
    logic     updated_reg, updated_next;
    div_req_t div_req;
    div_rsp_t div_rsp;

    trm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        smp_msg_next   = smp_msg_reg;
        smp_byte_next  = smp_byte_reg;
        smp_time_next  = smp_time_reg;
        last_time_next = last_time_reg;
        last_msg_next  = last_msg_reg;
        last_byte_next = last_byte_reg;
        elapsed_next   = elapsed_reg;
        rise_msg_next  = rise_msg_reg;
        rise_byte_next = rise_byte_reg;
        msg_rate_next  = msg_rate_reg;
        byte_rate_next = byte_rate_reg;
        updated_next   = updated_reg;
        div_req.start    = 1'b0;
        div_req.dividend = rise_msg_reg;
        div_req.divisor  = elapsed_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    smp_msg_next  = samples.message_total;
                    smp_byte_next = samples.byte_total;
                    smp_time_next = samples.sample_time;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (smp_time_reg > last_time_reg)
                begin
                    elapsed_next   = smp_time_reg - last_time_reg;
                    rise_msg_next  = (smp_msg_reg >= last_msg_reg) ?
                                     smp_msg_reg - last_msg_reg : '0;
                    rise_byte_next = (smp_byte_reg >= last_byte_reg) ?
                                     smp_byte_reg - last_byte_reg : '0;
                    last_time_next = smp_time_reg;
                    last_msg_next  = smp_msg_reg;
                    last_byte_next = smp_byte_reg;
                    updated_next   = 1'b1;
                    state_next     = S_MSG_GO;
                end
                else
                begin
                    updated_next = 1'b0;
                    state_next   = S_OUT;
                end
            end
            S_MSG_GO:
            begin
                div_req.start = 1'b1;
                state_next    = S_MSG_WAIT;
            end
            S_MSG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    msg_rate_next = div_rsp.quotient;
                    state_next    = S_BYTE_GO;
                end
            end
            S_BYTE_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = rise_byte_reg;
                state_next       = S_BYTE_WAIT;
            end
            S_BYTE_WAIT:
            begin
                if (div_rsp.done)
                begin
                    byte_rate_next = div_rsp.quotient;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (rates.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            smp_msg_reg   <= '0;
            smp_byte_reg  <= '0;
            smp_time_reg  <= '0;
            last_time_reg <= '0;
            last_msg_reg  <= '0;
            last_byte_reg <= '0;
            elapsed_reg   <= '0;
            rise_msg_reg  <= '0;
            rise_byte_reg <= '0;
            msg_rate_reg  <= '0;
            byte_rate_reg <= '0;
            updated_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            smp_msg_reg   <= smp_msg_next;
            smp_byte_reg  <= smp_byte_next;
            smp_time_reg  <= smp_time_next;
            last_time_reg <= last_time_next;
            last_msg_reg  <= last_msg_next;
            last_byte_reg <= last_byte_next;
            elapsed_reg   <= elapsed_next;
            rise_msg_reg  <= rise_msg_next;
            rise_byte_reg <= rise_byte_next;
            msg_rate_reg  <= msg_rate_next;
            byte_rate_reg <= byte_rate_next;
            updated_reg   <= updated_next;
        end
    end

    assign samples.ready      = (state_reg == S_IDLE);
    assign rates.valid        = (state_reg == S_OUT);
    assign rates.message_rate = msg_rate_reg;
    assign rates.byte_rate    = byte_rate_reg;
    assign rates.updated      = updated_reg;

`ifndef SYNTH
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> state_reg == S_CHECK)
        else $error("accepted beat not checked");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(samples.ready && rates.valid))
        else $error("input open while result pending");

    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_MSG_WAIT || state_reg == S_BYTE_WAIT))
        else $error("divider result not awaited");

    a_wait_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MSG_WAIT || state_reg == S_BYTE_WAIT) |->
        (div_rsp.busy || div_rsp.done))
        else $error("waiting with no divider run");

    a_no_update_stable: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rates.valid) && !rates.updated |-> $stable(last_time_reg))
        else $error("stored time moved without update");
`endif

endmodule

### tb/sv/throughput_rate_meter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// throughput_rate_meter_tb
// Self-checking bench for the rate meter. A directed table covers reset
// state, stale and equal timestamps, falling totals and extreme values;
// random samples follow, mostly well-formed runs of rising totals and
// timestamps. Results are checked against pinned rows or a bench model.
// ----------------------------------------------------------------------------
module throughput_rate_meter_tb;
    import trm_pkg::*;

    localparam int      RANDOM_ITEMS = 1130;
    localparam int      QUIET_ITEMS  = 80;
    localparam int      HOLD_CYCLES  = 1500;
    localparam int      HOLD_AFTER   = 30;
    localparam int      DRAIN_CYCLES = 200;
    localparam int      IDLE_LIMIT   = 20000;
    localparam int      HEAD_ROWS    = 12;
    localparam int      ROW_COUNT    = 16;
    localparam word_t   ALL_ONES     = '1;
    localparam word_t   TOP_BIT      = 64'h8000_0000_0000_0000;

    typedef struct packed {
        word_t message_rate;
        word_t byte_rate;
        logic  updated;
    } rate_beat_t;

    typedef struct packed {
        word_t      msgs;
        word_t      bytes;
        word_t      stamp;
        logic       pinned;
        rate_beat_t want;
    } stim_row_t;

    // rows past HEAD_ROWS run last: their timestamps leave no room to advance
    localparam stim_row_t STIM_ROWS [ROW_COUNT] = '{
        '{64'd5, 64'd7, 64'd0, 1'b1, '{64'd0, 64'd0, 1'b0}},
        '{ALL_ONES, ALL_ONES, 64'd1, 1'b1, '{ALL_ONES, ALL_ONES, 1'b1}},
        '{64'd3, 64'd3, 64'd1, 1'b1, '{ALL_ONES, ALL_ONES, 1'b0}},
        '{64'd9, 64'd9, 64'd0, 1'b1, '{ALL_ONES, ALL_ONES, 1'b0}},
        '{64'd0, 64'd0, 64'd2, 1'b1, '{64'd0, 64'd0, 1'b1}},
        '{64'd100, 64'd1000, 64'd12, 1'b1, '{64'd10, 64'd100, 1'b1}},
        '{64'd100, 64'd1000, 64'd13, 1'b1, '{64'd0, 64'd0, 1'b1}},
        '{TOP_BIT, ALL_ONES, 64'd14, 1'b0, '{64'd0, 64'd0, 1'b0}},
        '{TOP_BIT, ALL_ONES, 64'd14, 1'b0, '{64'd0, 64'd0, 1'b0}},
        '{TOP_BIT + 64'd7, ALL_ONES, 64'd17, 1'b1, '{64'd2, 64'd0, 1'b1}},
        '{64'd1, 64'd5, 64'd20, 1'b1, '{64'd0, 64'd0, 1'b1}},
        '{64'd1000, 64'h0000_0100_0000_0005, 64'd1020, 1'b0, '{64'd0, 64'd0, 1'b0}},
        '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, ALL_ONES - 64'd1,
          1'b0, '{64'd0, 64'd0, 1'b0}},
        '{ALL_ONES, ALL_ONES, ALL_ONES, 1'b0, '{64'd0, 64'd0, 1'b0}},
        '{64'd0, 64'd0, ALL_ONES, 1'b0, '{64'd0, 64'd0, 1'b0}},
        '{ALL_ONES, 64'd0, 64'd0, 1'b0, '{64'd0, 64'd0, 1'b0}}
    };

    logic clk;
    logic rst_n;

    trm_sample_if sample_bus ();
    trm_result_if rate_bus ();

    throughput_rate_meter i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_bus),
        .rates   (rate_bus)
    );

    word_t      meter_time;
    word_t      meter_msgs;
    word_t      meter_bytes;
    word_t      held_msg_rate;
    word_t      held_byte_rate;
    rate_beat_t expected_rates [$];

    bit         pinned_valid;
    rate_beat_t pinned_rates;
    bit         quiet;
    bit         hold_done;
    int         results_seen;
    int         err_count;
    int         idle_cycles;

    word_t      gen_time;
    word_t      gen_msgs;
    word_t      gen_bytes;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    function automatic word_t rise_of(word_t now, word_t prev);
        return (now >= prev) ? now - prev : '0;
    endfunction

    function automatic rate_beat_t step_meter(word_t msgs, word_t bytes, word_t stamp);
        rate_beat_t beat;
        word_t      elapsed;
        beat.updated = 1'b0;
        if (stamp > meter_time)
        begin
            elapsed        = stamp - meter_time;
            held_msg_rate  = rise_of(msgs, meter_msgs) / elapsed;
            held_byte_rate = rise_of(bytes, meter_bytes) / elapsed;
            meter_time     = stamp;
            meter_msgs     = msgs;
            meter_bytes    = bytes;
            beat.updated   = 1'b1;
        end
        beat.message_rate = held_msg_rate;
        beat.byte_rate    = held_byte_rate;
        return beat;
    endfunction

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic word_t rand_bits(int unsigned w);
        word_t v;
        v = rand_word();
        if (w == 0)
            return '0;
        if (w >= 64)
            return v;
        return v & ((64'd1 << w) - 64'd1);
    endfunction

    function automatic word_t rand_step();
        if ($urandom_range(0, 15) == 0)
            return 64'd1 + rand_bits($urandom_range(13, 40));
        return 64'd1 + rand_bits($urandom_range(0, 12));
    endfunction

    // called at a falling edge, returns at a falling edge after the beat
    task automatic send_sample(word_t msgs, word_t bytes, word_t stamp,
                               logic pinned, rate_beat_t want);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        pinned_valid              = pinned;
        pinned_rates              = want;
        sample_bus.valid         <= 1'b1;
        sample_bus.message_total <= msgs;
        sample_bus.byte_total    <= bytes;
        sample_bus.sample_time   <= stamp;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        @(negedge clk);
    endtask

    task automatic send_row(int idx);
        send_sample(STIM_ROWS[idx].msgs, STIM_ROWS[idx].bytes, STIM_ROWS[idx].stamp,
                    STIM_ROWS[idx].pinned, STIM_ROWS[idx].want);
    endtask

    always @(posedge clk)
    begin
        rate_beat_t modeled;
        if (rst_n && sample_bus.valid && sample_bus.ready)
        begin
            modeled = step_meter(sample_bus.message_total, sample_bus.byte_total,
                                 sample_bus.sample_time);
            expected_rates.push_back(pinned_valid ? pinned_rates : modeled);
        end
    end

    always @(posedge clk)
    begin
        rate_beat_t want;
        if (rst_n && rate_bus.valid && rate_bus.ready)
        begin
            results_seen++;
            if (expected_rates.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                want = expected_rates.pop_front();
                if (rate_bus.message_rate !== want.message_rate)
                    report_mismatch($sformatf("message_rate got %h want %h",
                                              rate_bus.message_rate, want.message_rate));
                if (rate_bus.byte_rate !== want.byte_rate)
                    report_mismatch($sformatf("byte_rate got %h want %h",
                                              rate_bus.byte_rate, want.byte_rate));
                if (rate_bus.updated !== want.updated)
                    report_mismatch($sformatf("updated got %b want %b",
                                              rate_bus.updated, want.updated));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_bus.valid && sample_bus.ready) ||
            (rate_bus.valid && rate_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int stall_left;
        rate_bus.ready = 1'b0;
        stall_left     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                rate_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                rate_bus.ready <= 1'b0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                rate_bus.ready <= 1'b0;
                stall_left = $urandom_range(1, 5) - 1;
            end
            else
                rate_bus.ready <= 1'b1;
        end
    end

    initial
    begin
        rate_beat_t none;
        word_t      stamp;
        int         kind;
        none                     = '0;
        clk                      = 1'b0;
        rst_n                    = 1'b0;
        sample_bus.valid         = 1'b0;
        sample_bus.message_total = '0;
        sample_bus.byte_total    = '0;
        sample_bus.sample_time   = '0;
        pinned_valid             = 1'b0;
        pinned_rates             = '0;
        quiet                    = 1'b0;
        hold_done                = 1'b0;
        results_seen             = 0;
        err_count                = 0;
        idle_cycles              = 0;
        meter_time               = '0;
        meter_msgs               = '0;
        meter_bytes              = '0;
        held_msg_rate            = '0;
        held_byte_rate           = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < HEAD_ROWS; i++)
            send_row(i);

        gen_time  = STIM_ROWS[HEAD_ROWS-1].stamp;
        gen_msgs  = STIM_ROWS[HEAD_ROWS-1].msgs;
        gen_bytes = STIM_ROWS[HEAD_ROWS-1].bytes;

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                gen_time  += rand_step();
                gen_msgs  += rand_bits($urandom_range(0, 64));
                gen_bytes += rand_bits($urandom_range(0, 64));
                send_sample(gen_msgs, gen_bytes, gen_time, 1'b0, none);
            end
            else if (kind < 9)
            begin
                if ($urandom_range(0, 2) == 0)
                    stamp = gen_time;
                else
                    stamp = rand_word() % (gen_time + 64'd1);
                send_sample(rand_word(), rand_word(), stamp, 1'b0, none);
            end
            else
            begin
                gen_time += rand_step();
                gen_msgs  = rand_word();
                gen_bytes = rand_word();
                send_sample(gen_msgs, gen_bytes, gen_time, 1'b0, none);
            end
        end

        for (int i = HEAD_ROWS; i < ROW_COUNT; i++)
            send_row(i);

        sample_bus.valid <= 1'b0;
        while (expected_rates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
rtl/core/trm_pkg.sv
rtl/core/trm_if.sv
rtl/core/trm_div.sv
rtl/core/throughput_rate_meter.sv
tb/sv/throughput_rate_meter_tb.sv
